// ----- sv/mcss_pkg.sv -----
`default_nettype none

package mcss_pkg;

    localparam int TABLE_DEPTH = 2048;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int LIT_W       = 11;
    localparam int VC_W        = 10;
    localparam int IDX_W       = ((ADDR_W > LIT_W) ? ADDR_W : LIT_W) + 1;
    localparam int COV_W       = 31;
    localparam int RES_W       = 30;
    localparam int PROD_W      = 2 * RES_W;
    localparam int MU_W        = 31;
    localparam int REM_W       = 32;

    localparam logic [RES_W-1:0] PRIME_MOD  = 30'd1000000007;
    localparam logic [VC_W-1:0]  VC_RESET   = 10'd1;
    localparam logic [MU_W-1:0]  BARRETT_MU = 31'((64'd1 << PROD_W) / 64'd1000000007);

    localparam logic FUNC_WRITE   = 1'b0;
    localparam logic FUNC_LITERAL = 1'b1;

    typedef struct packed {
        logic valid;
        logic last;
    } beat_tag_t;

endpackage

`default_nettype wire

// ----- sv/mcss_score.sv -----
`default_nettype none

module mcss_score
    import mcss_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             adv,
    input  wire beat_tag_t        tag_in,
    input  wire logic [COV_W-1:0] x,
    output beat_tag_t             tag_out,
    output logic      [RES_W-1:0] score
);

    beat_tag_t tag_a_reg, tag_b_reg, tag_c_reg, tag_d_reg, tag_e_reg, tag_f_reg;

    logic [RES_W-1:0]    r_reg, r_next;
    logic                one_a_reg, one_b_reg, one_c_reg, one_d_reg, one_e_reg;
    logic [PROD_W-1:0]   sq_reg;
    logic [RES_W-1:0]    rb_reg;
    logic [PROD_W-1:0]   s_reg;
    logic [2*MU_W-1:0]   q2_reg;
    logic [REM_W-1:0]    slo_d_reg, slo_e_reg;
    logic [REM_W-1:0]    t_reg;
    logic [RES_W-1:0]    g_reg, g_next;

    logic [COV_W:0]      x_m1, x_m2;
    logic [REM_W-1:0]    rem, rem_m1, rem_m2;

    always_comb
    begin
        x_m1 = {1'b0, x} - (COV_W + 1)'(PRIME_MOD);
        x_m2 = {1'b0, x} - (COV_W + 1)'({PRIME_MOD, 1'b0});
        if (!x_m2[COV_W])
        begin
            r_next = x_m2[RES_W-1:0];
        end
        else if (!x_m1[COV_W])
        begin
            r_next = x_m1[RES_W-1:0];
        end
        else
        begin
            r_next = x[RES_W-1:0];
        end
    end

    always_comb
    begin
        rem    = slo_e_reg - t_reg;
        rem_m1 = rem - REM_W'(PRIME_MOD);
        rem_m2 = rem - REM_W'({PRIME_MOD, 1'b0});
        if (one_e_reg)
        begin
            g_next = '0;
        end
        else if (rem >= REM_W'({PRIME_MOD, 1'b0}))
        begin
            g_next = rem_m2[RES_W-1:0];
        end
        else if (rem >= REM_W'(PRIME_MOD))
        begin
            g_next = rem_m1[RES_W-1:0];
        end
        else
        begin
            g_next = rem[RES_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_a_reg <= '0;
            tag_b_reg <= '0;
            tag_c_reg <= '0;
            tag_d_reg <= '0;
            tag_e_reg <= '0;
            tag_f_reg <= '0;
        end
        else if (adv)
        begin
            tag_a_reg <= tag_in;
            tag_b_reg <= tag_a_reg;
            tag_c_reg <= tag_b_reg;
            tag_d_reg <= tag_c_reg;
            tag_e_reg <= tag_d_reg;
            tag_f_reg <= tag_e_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r_reg     <= r_next;
            one_a_reg <= (r_next == RES_W'(1));
            sq_reg    <= r_reg * r_reg;
            rb_reg    <= r_reg;
            one_b_reg <= one_a_reg;
            s_reg     <= sq_reg + PROD_W'(rb_reg) + PROD_W'(1);
            one_c_reg <= one_b_reg;
            q2_reg    <= s_reg[PROD_W-1:RES_W-1] * BARRETT_MU;
            slo_d_reg <= s_reg[REM_W-1:0];
            one_d_reg <= one_c_reg;
            t_reg     <= REM_W'(q2_reg[2*MU_W-1:RES_W+1]) * REM_W'(PRIME_MOD);
            slo_e_reg <= slo_d_reg;
            one_e_reg <= one_d_reg;
            g_reg     <= g_next;
        end
    end

    assign tag_out = tag_f_reg;
    assign score   = g_reg;

endmodule

`default_nettype wire

// ----- sv/modular_coverage_score_sum_unit.sv -----
`default_nettype none

// Coverage score accumulator. A write beat (func 0) stores coverage_value at entry
// literal + var_count of a 2048-entry table; a literal beat (func 1) reads the count x
// there and adds x*x + x + 1 mod 1000000007 (zero when x is 1 mod that prime) to a
// running sum, and a literal beat with last_literal set emits the sum on solution_sum
// and clears it. Indexes outside the table drop writes and read as zero. The block
// takes one beat per cycle unless stalled, limited by the single access port of the
// table memory; a result passes the read register, mcss_score and output register.
// Table entries hold no defined value until written, so no clearing pass runs after
// reset. The var_count register may be written only while no beat is in flight.

module modular_coverage_score_sum_unit
    import mcss_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [VC_W-1:0]         var_count,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic                    func,
    input  wire logic signed [LIT_W-1:0] literal,
    input  wire logic [COV_W-1:0]        coverage_value,
    input  wire logic                    last_literal,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic [RES_W-1:0]             solution_sum
);

    logic [COV_W-1:0]        table_mem [TABLE_DEPTH];

    logic [VC_W-1:0]         vc_reg;
    beat_tag_t               rd_tag_reg;
    logic                    rd_hit_reg;
    logic [COV_W-1:0]        rd_data_reg;
    logic [RES_W-1:0]        sum_reg, sum_next;
    logic                    out_valid_reg;
    logic [RES_W-1:0]        out_sum_reg;

    logic                    adv;
    logic                    accept;
    logic signed [IDX_W-1:0] idx;
    logic                    hit;
    logic [ADDR_W-1:0]       addr;
    beat_tag_t               sc_tag;
    logic [RES_W-1:0]        sc_score;
    logic [COV_W-1:0]        x;
    logic [RES_W:0]          acc, acc_m;

    assign adv       = !(sc_tag.valid && sc_tag.last && out_valid_reg && out_stall);
    assign in_stall  = !adv;
    assign accept    = in_valid && adv;
    assign cfg_ready = 1'b1;

    assign idx  = IDX_W'(literal) + $signed(IDX_W'(vc_reg));
    assign hit  = !idx[IDX_W-1] && (idx[IDX_W-1:0] < IDX_W'(TABLE_DEPTH));
    assign addr = idx[ADDR_W-1:0];
    assign x    = rd_hit_reg ? rd_data_reg : '0;

    always_ff @(posedge clk)
    begin
        if (accept && hit)
        begin
            if (func == FUNC_WRITE)
            begin
                table_mem[addr] <= coverage_value;
            end
            else
            begin
                rd_data_reg <= table_mem[addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rd_hit_reg <= hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= VC_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            vc_reg <= var_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_tag_reg <= '0;
        end
        else if (adv)
        begin
            rd_tag_reg.valid <= accept && (func == FUNC_LITERAL);
            rd_tag_reg.last  <= last_literal;
        end
    end

    mcss_score u_score (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .tag_in  (rd_tag_reg),
        .x       (x),
        .tag_out (sc_tag),
        .score   (sc_score)
    );

    always_comb
    begin
        acc   = {1'b0, sum_reg} + {1'b0, sc_score};
        acc_m = acc - (RES_W + 1)'(PRIME_MOD);
        if (acc >= (RES_W + 1)'(PRIME_MOD))
        begin
            sum_next = acc_m[RES_W-1:0];
        end
        else
        begin
            sum_next = acc[RES_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv && sc_tag.valid && sc_tag.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (adv && sc_tag.valid)
            begin
                if (sc_tag.last)
                begin
                    sum_reg <= '0;
                end
                else
                begin
                    sum_reg <= sum_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && sc_tag.valid && sc_tag.last)
        begin
            out_sum_reg <= sum_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign solution_sum = out_sum_reg;

endmodule

`default_nettype wire
